// File: sv/rotd_pkg.sv
// rotd_pkg: shared types and constants for the relocation offset table decoder
// no dependencies; used by every module of the block

package rotd_pkg;

    localparam int ADDR_WIDTH = 32;

    localparam logic [7:0] VAL6_MASK = 8'h3F;

    localparam logic [1:0] LEFT_MID  = 2'd1;
    localparam logic [1:0] LEFT_LONG = 2'd3;

    typedef enum logic [1:0] {
        TAG_END   = 2'b00,
        TAG_SHORT = 2'b01,
        TAG_MID   = 2'b10,
        TAG_LONG  = 2'b11
    } tag_t;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       table_start;
    } item_t;

    typedef struct packed {
        logic [31:0] location_offset;
        logic [31:0] fixup_address;
        logic        table_end;
    } res_t;

endpackage

// File: sv/rotd_in_stage.sv
// rotd_in_stage: input register holding one table byte item
// depends on rotd_pkg

module rotd_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     table_byte,
    input  logic           table_start,
    input  logic           take,
    output logic           item_valid,
    output rotd_pkg::item_t item
);

    logic            vld_reg;
    logic            vld_next;
    rotd_pkg::item_t item_reg;
    logic            accept;

    assign in_ready = !vld_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.table_byte  <= table_byte;
            item_reg.table_start <= table_start;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

// File: sv/rotd_decode.sv
// rotd_decode: entry assembly, running location and fixup address
// depends on rotd_pkg; fed by rotd_in_stage, drains into rotd_out_stage

module rotd_decode #(
    parameter int ADDR_WIDTH = rotd_pkg::ADDR_WIDTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [31:0]     data_base,
    input  logic            item_valid,
    input  rotd_pkg::item_t item,
    input  logic            take,
    output logic            emit,
    output rotd_pkg::res_t  res
);

    logic [ADDR_WIDTH-1:0] loc_reg;
    logic [ADDR_WIDTH-1:0] loc_next;
    logic [ADDR_WIDTH-1:0] fix_reg;
    logic [ADDR_WIDTH-1:0] fix_next;
    logic [31:0]           base_reg;
    logic [29:0]           part_reg;
    logic [29:0]           part_next;
    logic [1:0]            left_reg;
    logic [1:0]            left_next;
    logic                  done_reg;
    logic                  done_next;

    logic [ADDR_WIDTH-1:0] eff_loc;
    logic [ADDR_WIDTH-1:0] eff_fix;
    logic [29:0]           eff_part;
    logic [1:0]            eff_left;
    logic                  eff_done;
    logic [29:0]           shifted;
    logic [1:0]            left_dec;
    logic [29:0]           add_val;
    logic [ADDR_WIDTH-1:0] step;
    logic                  finish;
    logic                  is_end;
    rotd_pkg::tag_t        tag;
    logic                  cfg_wr;

    assign cfg_ready = !item_valid;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        eff_loc  = item.table_start ? '0 : loc_reg;
        eff_fix  = item.table_start ? ADDR_WIDTH'(base_reg) : fix_reg;
        eff_part = item.table_start ? '0 : part_reg;
        eff_left = item.table_start ? '0 : left_reg;
        eff_done = item.table_start ? 1'b0 : done_reg;
        shifted  = {eff_part[21:0], item.table_byte};
        left_dec = eff_left - 2'd1;
        tag      = rotd_pkg::tag_t'(item.table_byte[7:6]);

        part_next = eff_part;
        left_next = eff_left;
        done_next = eff_done;
        add_val   = '0;
        finish    = 1'b0;
        is_end    = 1'b0;

        if (eff_done)
        begin
            // bytes past the terminator are dropped
        end
        else if (eff_left != 2'd0)
        begin
            part_next = shifted;
            left_next = left_dec;
            if (left_dec == 2'd0)
            begin
                finish  = 1'b1;
                add_val = shifted;
            end
        end
        else
        begin
            case (tag)
                rotd_pkg::TAG_END:
                begin
                    done_next = 1'b1;
                    is_end    = 1'b1;
                end
                rotd_pkg::TAG_SHORT:
                begin
                    finish  = 1'b1;
                    add_val = 30'(item.table_byte & rotd_pkg::VAL6_MASK);
                end
                rotd_pkg::TAG_MID:
                begin
                    part_next = 30'(item.table_byte & rotd_pkg::VAL6_MASK);
                    left_next = rotd_pkg::LEFT_MID;
                end
                rotd_pkg::TAG_LONG:
                begin
                    part_next = 30'(item.table_byte & rotd_pkg::VAL6_MASK);
                    left_next = rotd_pkg::LEFT_LONG;
                end
                default:
                begin
                    part_next = 30'(item.table_byte & rotd_pkg::VAL6_MASK);
                    left_next = rotd_pkg::LEFT_LONG;
                end
            endcase
        end

        step     = ADDR_WIDTH'({add_val, 2'b00});
        loc_next = eff_loc + step;
        fix_next = eff_fix + step;

        emit                = finish || is_end;
        res.location_offset = 32'(loc_next);
        res.fixup_address   = 32'(fix_next);
        res.table_end       = is_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loc_reg  <= '0;
            fix_reg  <= '0;
            base_reg <= '0;
            part_reg <= '0;
            left_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            base_reg <= data_base;
            fix_reg  <= loc_reg + ADDR_WIDTH'(data_base);
        end
        else if (take)
        begin
            loc_reg  <= loc_next;
            fix_reg  <= fix_next;
            part_reg <= part_next;
            left_reg <= left_next;
            done_reg <= done_next;
        end
    end

    a_fix_tracks_loc: assert property (@(posedge clk) disable iff (!rst_n)
        fix_reg == loc_reg + ADDR_WIDTH'(base_reg))
        else $error("fixup address out of step with location");

    a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        take && !item.table_start && done_reg |-> !emit)
        else $error("result after table end");

    a_end_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        take && emit && res.table_end |=> done_reg)
        else $error("terminator did not close table");

endmodule

// File: sv/rotd_out_stage.sv
// rotd_out_stage: result register and pipeline advance control
// depends on rotd_pkg; takes results from rotd_decode

module rotd_out_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    input  logic           emit,
    input  rotd_pkg::res_t res,
    output logic           take,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    location_offset,
    output logic [31:0]    fixup_address,
    output logic           table_end
);

    logic           vld_reg;
    logic           vld_next;
    rotd_pkg::res_t res_reg;
    logic           load;

    assign take = src_valid && (!vld_reg || out_ready);
    assign load = take && emit;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = vld_reg;
    assign location_offset = res_reg.location_offset;
    assign fixup_address   = res_reg.fixup_address;
    assign table_end       = res_reg.table_end;

endmodule

// File: sv/relocation_offset_table_decoder_top.sv
// relocation_offset_table_decoder_top: byte-wise relocation offset table decoder
// depends on rotd_pkg, rotd_in_stage, rotd_decode, rotd_out_stage
//
// channel   handshake             payload
// input     in_valid / in_ready   table_byte, table_start
// result    out_valid / out_ready location_offset, fixup_address, table_end
// config    cfg_valid / cfg_ready data_base
//
// one byte per cycle when results are not stalled; path: input register, then result register
// the location and fixup adders in the decode stage set the cycle time
// reset clears location, entry assembly, end mark and data base
// a stalled result holds the decode stage and the input register, even for bytes with no result
// config writes wait until the input register is empty

module relocation_offset_table_decoder_top #(
    parameter int ADDR_WIDTH = rotd_pkg::ADDR_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  table_byte,
    input  logic        table_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] location_offset,
    output logic [31:0] fixup_address,
    output logic        table_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] data_base
);

    logic            item_valid;
    rotd_pkg::item_t item;
    logic            take;
    logic            emit;
    rotd_pkg::res_t  res;

    rotd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .table_byte  (table_byte),
        .table_start (table_start),
        .take        (take),
        .item_valid  (item_valid),
        .item        (item)
    );

    rotd_decode #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .data_base  (data_base),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .emit       (emit),
        .res        (res)
    );

    rotd_out_stage u_out_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .src_valid       (item_valid),
        .emit            (emit),
        .res             (res),
        .take            (take),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .location_offset (location_offset),
        .fixup_address   (fixup_address),
        .table_end       (table_end)
    );

endmodule

// File: bench/rotd_checker.sv
`timescale 1ns / 1ps
// rotd_checker: watches the byte, result and data_base channels of the decoder,
// predicts each fixup from the accepted table bytes and compares them in order
// depends on rotd_pkg

module rotd_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  table_byte,
    input  logic        table_start,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] location_offset,
    input  logic [31:0] fixup_address,
    input  logic        table_end,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] data_base,
    output int          mismatch_count,
    output int          results_due,
    output int          results_seen
);

    logic [31:0]    base_addr;
    logic [31:0]    running_loc;
    logic [29:0]    entry_bits;
    logic [1:0]     bytes_due;
    logic           end_seen;
    rotd_pkg::res_t fixups_due[$];
    int             errors;
    int             seen;

    assign mismatch_count = errors;
    assign results_seen   = seen;

    task automatic report(input string msg);
        $display("%0t ns checker: %s", $time, msg);
        errors++;
    endtask

    task automatic queue_fixup(input logic is_end);
        rotd_pkg::res_t r;
        r.location_offset = running_loc;
        r.fixup_address   = running_loc + base_addr;
        r.table_end       = is_end;
        fixups_due.push_back(r);
    endtask

    task automatic add_entry(input logic [29:0] value);
        running_loc = running_loc + {value, 2'b00};
        queue_fixup(1'b0);
    endtask

    task automatic decode_table_byte(input logic [7:0] b, input logic s);
        rotd_pkg::tag_t tag;
        if (s)
        begin
            running_loc = '0;
            entry_bits  = '0;
            bytes_due   = '0;
            end_seen    = 1'b0;
        end
        else if (end_seen)
            return;
        if (bytes_due != 0)
        begin
            entry_bits = {entry_bits[21:0], b};
            bytes_due  = bytes_due - 1'b1;
            if (bytes_due == 0)
                add_entry(entry_bits);
            return;
        end
        tag = rotd_pkg::tag_t'(b[7:6]);
        case (tag)
            rotd_pkg::TAG_END:
            begin
                end_seen = 1'b1;
                queue_fixup(1'b1);
            end
            rotd_pkg::TAG_SHORT:
                add_entry({22'd0, b & rotd_pkg::VAL6_MASK});
            rotd_pkg::TAG_MID:
            begin
                entry_bits = {22'd0, b & rotd_pkg::VAL6_MASK};
                bytes_due  = rotd_pkg::LEFT_MID;
            end
            default:
            begin
                entry_bits = {22'd0, b & rotd_pkg::VAL6_MASK};
                bytes_due  = rotd_pkg::LEFT_LONG;
            end
        endcase
    endtask

    task automatic check_fixup();
        rotd_pkg::res_t want;
        seen++;
        if (fixups_due.size() == 0)
        begin
            report($sformatf("result with nothing due: loc %h fix %h end %b",
                             location_offset, fixup_address, table_end));
            return;
        end
        want = fixups_due.pop_front();
        if (location_offset !== want.location_offset)
            report($sformatf("location_offset %h, want %h",
                             location_offset, want.location_offset));
        if (fixup_address !== want.fixup_address)
            report($sformatf("fixup_address %h, want %h",
                             fixup_address, want.fixup_address));
        if (table_end !== want.table_end)
            report($sformatf("table_end %b, want %b", table_end, want.table_end));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr   = '0;
            running_loc = '0;
            entry_bits  = '0;
            bytes_due   = '0;
            end_seen    = 1'b0;
            fixups_due.delete();
            results_due <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                base_addr = data_base;
            if (in_valid && in_ready)
                decode_table_byte(table_byte, table_start);
            if (out_valid && out_ready)
                check_fixup();
            results_due <= fixups_due.size();
        end
    end

    initial
    begin
        errors = 0;
        seen   = 0;
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for relocation_offset_table_decoder_top
// depends on rotd_pkg, the decoder RTL and rotd_checker

module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_GAP   = 6;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  table_byte;
    logic        table_start;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] location_offset;
    logic [31:0] fixup_address;
    logic        table_end;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] data_base;

    int mismatch_count;
    int results_due;
    int results_seen;

    bit tx_idle;
    bit rx_idle;
    bit hold_req;
    int bytes_sent;
    int junk_sent;
    int tables_sent;
    int base_writes;
    int stalled_cycles = 0;

    relocation_offset_table_decoder_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .table_byte      (table_byte),
        .table_start     (table_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .location_offset (location_offset),
        .fixup_address   (fixup_address),
        .table_end       (table_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .data_base       (data_base)
    );

    rotd_checker fixup_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .table_byte      (table_byte),
        .table_start     (table_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .location_offset (location_offset),
        .fixup_address   (fixup_address),
        .table_end       (table_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .data_base       (data_base),
        .mismatch_count  (mismatch_count),
        .results_due     (results_due),
        .results_seen    (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", stalled_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random back-pressure bursts and one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic s);
        in_valid    <= 1'b1;
        table_byte  <= b;
        table_start <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        if (tx_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        data_base <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        base_writes++;
    endtask

    // one table: random entries, terminator, up to two ignored bytes after it;
    // a broken table stops inside a long entry with no terminator
    task automatic send_table(input int entries, input bit broken);
        logic [31:0] bits;
        int len;
        int cut;
        int n;
        bit start;
        start = 1'b1;
        cut = broken ? $urandom_range(0, entries - 1) : -1;
        tables_sent++;
        for (int e = 0; e < entries; e++)
        begin
            case ($urandom_range(0, 7))
                0: bits = '0;
                1: bits = '1;
                default: bits = $urandom();
            endcase
            len = (e == cut) ? 4 : 1 << $urandom_range(0, 2);
            case (len)
                1: send_byte({rotd_pkg::TAG_SHORT, bits[5:0]}, start);
                2: send_byte({rotd_pkg::TAG_MID, bits[13:8]}, start);
                default: send_byte({rotd_pkg::TAG_LONG, bits[29:24]}, start);
            endcase
            start = 1'b0;
            if (e == cut)
            begin
                n = $urandom_range(0, 2);
                for (int k = 2; k > 2 - n; k--)
                    send_byte(bits[8*k +: 8], 1'b0);
                return;
            end
            for (int k = len - 2; k >= 0; k--)
                send_byte(bits[8*k +: 8], 1'b0);
        end
        send_byte({rotd_pkg::TAG_END, 6'($urandom())}, start);
        repeat ($urandom_range(0, 2))
        begin
            send_byte(8'($urandom()), 1'b0);
            junk_sent++;
        end
    endtask

    task automatic run_random(input int target);
        int pick;
        while (bytes_sent - junk_sent < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom()), 1'($urandom()));
            else if (pick == 1)
                send_table($urandom_range(1, 6), 1'b1);
            else if (pick == 2)
                send_table($urandom_range(20, 40), 1'b0);
            else
                send_table($urandom_range(0, 8), 1'b0);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        table_byte  = '0;
        table_start = 1'b0;
        cfg_valid   = 1'b0;
        data_base   = '0;
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        hold_req    = 1'b0;
        bytes_sent  = 0;
        junk_sent   = 0;
        tables_sent = 0;
        base_writes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no start after reset, each entry length at its maximum and at zero (long at one), data base at reset value
        send_byte({rotd_pkg::TAG_SHORT, 6'h3F}, 1'b0);
        send_byte({rotd_pkg::TAG_SHORT, 6'h00}, 1'b0);
        send_byte({rotd_pkg::TAG_MID, 6'h3F}, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte({rotd_pkg::TAG_MID, 6'h00}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte({rotd_pkg::TAG_LONG, 6'h3F}, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte({rotd_pkg::TAG_LONG, 6'h00}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte({rotd_pkg::TAG_END, 6'h00}, 1'b0);
        send_byte({rotd_pkg::TAG_SHORT, 6'h15}, 1'b0);
        send_byte({rotd_pkg::TAG_LONG, 6'h05}, 1'b0);
        junk_sent += 2;

        write_base(32'hFFFF_FFFF);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // start cutting a partial entry, data bytes that look like head bytes
        send_byte({rotd_pkg::TAG_SHORT, 6'h01}, 1'b1);
        send_byte({rotd_pkg::TAG_LONG, 6'h01}, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte({rotd_pkg::TAG_MID, 6'h00}, 1'b1);
        send_byte(8'hC0, 1'b0);
        send_byte({rotd_pkg::TAG_MID, 6'h3F}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte({rotd_pkg::TAG_END, 6'h3F}, 1'b0);
        send_byte({rotd_pkg::TAG_END, 6'h2A}, 1'b1);
        send_byte({rotd_pkg::TAG_SHORT, 6'h3F}, 1'b1);
        send_byte({rotd_pkg::TAG_END, 6'h01}, 1'b0);
        tables_sent += 5;

        write_base(32'h8000_0000);
        run_random(200);

        // long hold on the result side while bytes keep coming
        in_valid <= 1'b0;
        @(posedge clk);
        hold_req = 1'b1;
        repeat (3) send_table($urandom_range(8, 12), 1'b0);
        while (hold_req)
            @(posedge clk);

        write_base($urandom());
        run_random(450);
        write_base(32'h0000_0000);
        rx_idle = 1'b0;
        run_random(650);
        write_base($urandom());
        tx_idle = 1'b0;
        run_random(800);

        wait_drained();
        $display("covered %0d tables over %0d bytes (%0d after an end), %0d results checked",
                 tables_sent, bytes_sent, junk_sent, results_seen);
        $display("data_base written %0d times: all ones, top bit only, zero and random",
                 base_writes);
        if (mismatch_count == 0 && results_due == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
sv/rotd_pkg.sv
sv/rotd_in_stage.sv
sv/rotd_decode.sv
sv/rotd_out_stage.sv
sv/relocation_offset_table_decoder_top.sv
bench/rotd_checker.sv
bench/tb.sv
